// ===== rtl/chf_pkg.sv =====
// ----------------------------------------------------------------------------
// chf_pkg: shared types and constants for the compass heading block
// Vector widths, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package chf_pkg;

    // number of CORDIC rotation cells in the chain
    localparam int CORDIC_STEPS = 21;

    // x/y after scaling by 2^16 plus CORDIC gain headroom
    localparam int XY_W = 36;
    // angle accumulator, units of 1/32768 degree
    localparam int Z_W = 25;
    // raw sample and heading widths
    localparam int SAMPLE_W  = 16;
    localparam int HEADING_W = 16;
    // rounded angle plus declination
    localparam int SUM_W  = 17;
    // folded heading before saturation
    localparam int FOLD_W = 18;

    // angle constants
    localparam logic signed [Z_W-1:0]    QUARTER_FINE = 25'sd2949120;
    localparam logic signed [SUM_W-1:0]  HALF_TURN    = 17'sd23040;
    localparam logic signed [FOLD_W-1:0] FULL_TURN    = 18'sd46080;

    // declination after reset: 0.22 rad in 1/128 degree
    localparam logic signed [SAMPLE_W-1:0] DECL_RESET = 16'sd1613;

    // one beat moving through the rotation chain
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;   // input vector was 0,0
    } chf_vec_t;

    // atan(2^-step) in 1/32768 degree, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_fine(input int step);
        logic signed [Z_W-1:0] t;
        case (step)
            0:       t = 25'sd1474560;
            1:       t = 25'sd870484;
            2:       t = 25'sd459940;
            3:       t = 25'sd233473;
            4:       t = 25'sd117189;
            5:       t = 25'sd58652;
            6:       t = 25'sd29333;
            7:       t = 25'sd14667;
            8:       t = 25'sd7334;
            9:       t = 25'sd3667;
            10:      t = 25'sd1833;
            11:      t = 25'sd917;
            12:      t = 25'sd458;
            13:      t = 25'sd229;
            14:      t = 25'sd115;
            15:      t = 25'sd57;
            16:      t = 25'sd29;
            17:      t = 25'sd14;
            18:      t = 25'sd7;
            19:      t = 25'sd4;
            20:      t = 25'sd2;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/chf_prerot.sv =====
// ----------------------------------------------------------------------------
// chf_prerot: input stage of the rotation chain
// Scales the sample pair by 2^16, folds the left half plane onto the right
// half plane with a +/-90 degree start angle, and flags the zero vector.
// ----------------------------------------------------------------------------
module chf_prerot (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [chf_pkg::SAMPLE_W-1:0] in_x,
    input  logic signed [chf_pkg::SAMPLE_W-1:0] in_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output chf_pkg::chf_vec_t                out_vec
);

    localparam int PAD_W = chf_pkg::XY_W - chf_pkg::SAMPLE_W - 16;

    logic              valid_reg;
    chf_pkg::chf_vec_t vec_reg;
    chf_pkg::chf_vec_t vec_next;
    logic signed [chf_pkg::XY_W-1:0] sx;
    logic signed [chf_pkg::XY_W-1:0] sy;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    // scale and pre-rotate
    always_comb begin
        sx = {{PAD_W{in_x[chf_pkg::SAMPLE_W-1]}}, in_x, 16'h0000};
        sy = {{PAD_W{in_y[chf_pkg::SAMPLE_W-1]}}, in_y, 16'h0000};
        vec_next.zero = (in_x == '0) && (in_y == '0);
        if (!in_x[chf_pkg::SAMPLE_W-1]) begin
            vec_next.x = sx;
            vec_next.y = sy;
            vec_next.z = '0;
        end else if (!in_y[chf_pkg::SAMPLE_W-1]) begin
            vec_next.x = sy;
            vec_next.y = -sx;
            vec_next.z = chf_pkg::QUARTER_FINE;
        end else begin
            vec_next.x = -sy;
            vec_next.y = sx;
            vec_next.z = -chf_pkg::QUARTER_FINE;
        end
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            vec_reg <= vec_next;
        end
    end

endmodule

// ===== rtl/chf_cell.sv =====
// ----------------------------------------------------------------------------
// chf_cell: one CORDIC vectoring step
// Rotates the vector toward the x axis by atan(2^-STEP) and accumulates the
// angle; holds its beat while the next cell is full.
// ----------------------------------------------------------------------------
module chf_cell #(
    parameter int STEP = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  chf_pkg::chf_vec_t in_vec,
    output logic              out_valid,
    input  logic              out_ready,
    output chf_pkg::chf_vec_t out_vec
);

    logic              valid_reg;
    chf_pkg::chf_vec_t vec_reg;
    chf_pkg::chf_vec_t vec_next;
    logic signed [chf_pkg::XY_W-1:0] cur_x;
    logic signed [chf_pkg::XY_W-1:0] cur_y;
    logic signed [chf_pkg::XY_W-1:0] dx;
    logic signed [chf_pkg::XY_W-1:0] dy;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    // rotation step, direction set by the sign of y
    always_comb begin
        cur_x = in_vec.x;
        cur_y = in_vec.y;
        dx = cur_y >>> STEP;
        dy = cur_x >>> STEP;
        vec_next.zero = in_vec.zero;
        if (!cur_y[chf_pkg::XY_W-1]) begin
            vec_next.x = cur_x + dx;
            vec_next.y = cur_y - dy;
            vec_next.z = in_vec.z + chf_pkg::atan_fine(STEP);
        end else begin
            vec_next.x = cur_x - dx;
            vec_next.y = cur_y + dy;
            vec_next.z = in_vec.z - chf_pkg::atan_fine(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            vec_reg <= vec_next;
        end
    end

endmodule

// ===== rtl/chf_fold.sv =====
// ----------------------------------------------------------------------------
// chf_fold: angle rounding and compass fold
// Stage one rounds the CORDIC angle to 1/128 degree, clamps it to +/-180
// (0 for the zero vector) and adds the declination; stage two folds into
// 0..360 and saturates. The second stage is the output register.
// ----------------------------------------------------------------------------
module chf_fold (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic signed [chf_pkg::SAMPLE_W-1:0] declination,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  chf_pkg::chf_vec_t                   in_vec,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [chf_pkg::HEADING_W-1:0]       out_heading
);

    localparam int SHIFT_W = chf_pkg::Z_W - 8;

    logic                               sum_valid_reg;
    logic signed [chf_pkg::SUM_W-1:0]   sum_reg;
    logic signed [chf_pkg::SUM_W-1:0]   sum_next;
    logic                               sum_ready;
    logic                               head_valid_reg;
    logic [chf_pkg::HEADING_W-1:0]      head_reg;
    logic [chf_pkg::HEADING_W-1:0]      head_next;

    logic signed [chf_pkg::Z_W-1:0]     z_rnd;
    logic signed [SHIFT_W-1:0]          ang_raw;
    logic signed [chf_pkg::SUM_W-1:0]   ang;
    logic signed [chf_pkg::FOLD_W-1:0]  h0;
    logic signed [chf_pkg::FOLD_W-1:0]  h1;
    logic signed [chf_pkg::FOLD_W-1:0]  h2;

    assign sum_ready   = !head_valid_reg || out_ready;
    assign in_ready    = !sum_valid_reg || sum_ready;
    assign out_valid   = head_valid_reg;
    assign out_heading = head_reg;

    // round to 1/128 degree, clamp, add declination
    always_comb begin
        z_rnd   = in_vec.z + chf_pkg::Z_W'(128);
        ang_raw = SHIFT_W'(z_rnd >>> 8);
        if (in_vec.zero) begin
            ang = '0;
        end else if (ang_raw > SHIFT_W'(chf_pkg::HALF_TURN)) begin
            ang = chf_pkg::HALF_TURN;
        end else if (ang_raw < -SHIFT_W'(chf_pkg::HALF_TURN)) begin
            ang = -chf_pkg::HALF_TURN;
        end else begin
            ang = chf_pkg::SUM_W'(ang_raw);
        end
        sum_next = ang + chf_pkg::SUM_W'(declination);
    end

    // fold into the compass range and saturate
    always_comb begin
        h0 = chf_pkg::FOLD_W'(sum_reg);
        h1 = h0[chf_pkg::FOLD_W-1] ? h0 + chf_pkg::FULL_TURN : h0;
        h2 = (h1 > chf_pkg::FULL_TURN) ? h1 - chf_pkg::FULL_TURN : h1;
        if (h2[chf_pkg::FOLD_W-1]) begin
            head_next = '0;
        end else if (h2 > chf_pkg::FULL_TURN) begin
            head_next = chf_pkg::HEADING_W'(chf_pkg::FULL_TURN);
        end else begin
            head_next = chf_pkg::HEADING_W'(h2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg  <= 1'b0;
            head_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                sum_valid_reg <= in_valid;
            end
            if (sum_ready) begin
                head_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            sum_reg <= sum_next;
        end
        if (sum_ready) begin
            head_reg <= head_next;
        end
    end

endmodule

// ===== rtl/compass_heading_from_xy.sv =====
// ----------------------------------------------------------------------------
// compass_heading_from_xy: magnetometer X/Y to compass heading
// Pipelined CORDIC atan2 with declination and 0..360 degree fold.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat carries a signed X/Y sample pair. m_ channel: one
//   beat carries the heading, 0..46080 in 1/128 degree (46080 = 360 deg).
//   cfg_ channel: signed declination in 1/128 degree, written while idle;
//   cfg_ready is always high.
//   The pipeline is one pre-rotation cell, 21 CORDIC cells and two
//   fold stages, each a register. One beat is accepted per clock while the
//   receiver keeps up; the chain of cell registers sets that rate.
//   Each cell holds a beat and passes it on when its neighbor has room, so
//   a stalled receiver fills the chain from the output back; s_tready drops
//   only once every stage is full, and bubbles are squeezed out meanwhile.
//   The zero vector gives an angle of 0, so the heading is the folded
//   declination.
//   Reset (aresetn low, synchronous) empties the pipeline and loads the
//   declination with 1613 (0.22 rad).
// ----------------------------------------------------------------------------
module compass_heading_from_xy #(
    parameter int CORDIC_STEPS = chf_pkg::CORDIC_STEPS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input samples
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] field_x, [31:16] field_y
    // heading results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] heading
    // declination register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // [15:0] declination
);

    logic signed [chf_pkg::SAMPLE_W-1:0] decl_reg;

    chf_pkg::chf_vec_t vec   [0:CORDIC_STEPS];
    logic              valid [0:CORDIC_STEPS];
    logic              ready [0:CORDIC_STEPS];

    // declination register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decl_reg <= chf_pkg::DECL_RESET;
        end else if (cfg_valid) begin
            decl_reg <= cfg_data;
        end
    end

    // scale and pre-rotate
    chf_prerot u_prerot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[15:0]),
        .in_y      (s_tdata[31:16]),
        .out_valid (valid[0]),
        .out_ready (ready[0]),
        .out_vec   (vec[0])
    );

    // chain of rotation cells
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        chf_cell #(
            .STEP (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid[i]),
            .in_ready  (ready[i]),
            .in_vec    (vec[i]),
            .out_valid (valid[i+1]),
            .out_ready (ready[i+1]),
            .out_vec   (vec[i+1])
        );
    end

    // round, add declination, fold
    chf_fold u_fold (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .declination (decl_reg),
        .in_valid    (valid[CORDIC_STEPS]),
        .in_ready    (ready[CORDIC_STEPS]),
        .in_vec      (vec[CORDIC_STEPS]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_heading (m_tdata)
    );

endmodule

// ===== tb/compass_heading_from_xy_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_heading_from_xy_test: self-checking bench for the compass heading
// Sends X/Y sample pairs over the s_ stream and predicts each heading with a
// bit-exact CORDIC model kept in the bench. Every m_ beat is checked in order.
// The declination register is swept through its extremes and random values.
// Both stream sides idle at random, and the receiver holds off long enough to
// stall the input.
// ----------------------------------------------------------------------------
module compass_heading_from_xy_test;

    localparam int     CYCLE_LIMIT    = 600000;
    localparam int     PIPE_LATENCY   = 24;
    localparam int     SAMPLE_W       = chf_pkg::SAMPLE_W;
    localparam int     HEADING_W      = chf_pkg::HEADING_W;
    localparam int     ROT_STEPS      = 21;
    localparam longint QUARTER_ANGLE  = 2949120;   // 90 deg in 1/32768 deg
    localparam int     HALF_CIRCLE    = 23040;     // 180 deg in 1/128 deg
    localparam int     FULL_CIRCLE    = 46080;     // 360 deg in 1/128 deg
    localparam int     DECL_AT_RESET  = 1613;
    // atan(2^-i) in 1/32768 degree
    localparam longint STEP_ANGLE [0:ROT_STEPS-1] = '{
        1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
        7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
    };

    typedef struct {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic [HEADING_W-1:0]       heading;
    } heading_exp_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;     // [15:0] field_x, [31:16] field_y
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;     // [15:0] heading
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [15:0]          cfg_data;    // [15:0] declination

    heading_exp_t               heading_q[$];
    logic signed [SAMPLE_W-1:0] decl_setting;
    int                         mismatch_count = 0;
    int                         cycle_count = 0;
    int                         hold_cycles = 0;
    bit                         tx_fast = 1'b0;
    bit                         rx_fast = 1'b0;

    compass_heading_from_xy u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("compass_heading_from_xy test failed");
            $finish;
        end
    end

    // heading for one sample pair: vectoring CORDIC, round, add declination, fold
    function automatic logic [HEADING_W-1:0] predict_heading(
            input logic signed [SAMPLE_W-1:0] fx,
            input logic signed [SAMPLE_W-1:0] fy,
            input logic signed [SAMPLE_W-1:0] decl);
        longint px;
        longint py;
        longint z;
        longint dx;
        longint dy;
        longint ang;
        int     sum;
        px  = longint'(fx) * 65536;
        py  = longint'(fy) * 65536;
        z   = 0;
        ang = 0;
        if (fx != 0 || fy != 0) begin
            // left half plane: rotate by a quarter turn first
            if (px < 0) begin
                dx = px;
                if (py >= 0) begin
                    px = py;
                    py = -dx;
                    z  = QUARTER_ANGLE;
                end else begin
                    px = -py;
                    py = dx;
                    z  = -QUARTER_ANGLE;
                end
            end
            for (int i = 0; i < ROT_STEPS; i++) begin
                dx = py >>> i;
                dy = px >>> i;
                if (py >= 0) begin
                    px += dx;
                    py -= dy;
                    z  += STEP_ANGLE[i];
                end else begin
                    px -= dx;
                    py += dy;
                    z  -= STEP_ANGLE[i];
                end
            end
            ang = (z + 128) >>> 8;
            if (ang > HALF_CIRCLE)
                ang = HALF_CIRCLE;
            if (ang < -HALF_CIRCLE)
                ang = -HALF_CIRCLE;
        end
        sum = int'(ang) + int'(decl);
        if (sum < 0)
            sum += FULL_CIRCLE;
        if (sum > FULL_CIRCLE)
            sum -= FULL_CIRCLE;
        // declination beyond half a turn can leave the sum out of range
        if (sum < 0)
            sum = 0;
        if (sum > FULL_CIRCLE)
            sum = FULL_CIRCLE;
        return HEADING_W'(sum);
    endfunction

    // random sample pair, biased to small, zero, axis, diagonal and extreme values
    function automatic void draw_sample(output logic signed [SAMPLE_W-1:0] fx,
                                        output logic signed [SAMPLE_W-1:0] fy);
        int pick;
        pick = $urandom_range(0, 99);
        fx = SAMPLE_W'($urandom);
        fy = SAMPLE_W'($urandom);
        if (pick < 15) begin
            fx = SAMPLE_W'($urandom_range(0, 16) - 8);
            fy = SAMPLE_W'($urandom_range(0, 16) - 8);
        end else if (pick < 20) begin
            fy = 0;
        end else if (pick < 25) begin
            fx = 0;
        end else if (pick < 30) begin
            fy = ($urandom_range(0, 1) != 0) ? fx : -fx;
        end else if (pick < 33) begin
            fx = 0;
            fy = 0;
        end else if (pick < 40) begin
            fx = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            fy = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
        end
    endfunction

    // one input beat, with a random gap ahead of it unless tx_fast is set
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] fx,
                               input logic signed [SAMPLE_W-1:0] fy);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {fy, fx};
        do @(posedge aclk); while (!s_tready);
        heading_q.push_back('{x: fx, y: fy, heading: predict_heading(fx, fy, decl_setting)});
    endtask

    // stop sending and wait for every outstanding heading
    task automatic wait_headings_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (heading_q.size() != 0);
    endtask

    // register write, only while the pipeline is empty
    task automatic write_declination(input logic signed [SAMPLE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        decl_setting = value;
    endtask

    // axes, corners and the zero vector under the declination from reset
    task automatic test_reset_declination();
        send_sample(0, 0);
        send_sample(-1, 0);
        send_sample(-32768, 0);
        send_sample(32767, 0);
        send_sample(0, 32767);
        send_sample(0, -32768);
        send_sample(-32768, -32768);
        send_sample(32767, 32767);
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        send_sample(-1, -1);
        send_sample(1, -1);
        wait_headings_drained();
    endtask

    // declination at its limits, including values that force saturation
    task automatic test_declination_extremes();
        int decl_list [5] = '{0, 23040, -23040, 32767, -32768};
        foreach (decl_list[k]) begin
            write_declination(SAMPLE_W'(decl_list[k]));
            send_sample(0, 0);
            send_sample(-5, 0);
            send_sample(-3, -3);
            wait_headings_drained();
        end
    endtask

    // random samples over several declination settings and idle mixes
    task automatic test_random_headings();
        logic signed [SAMPLE_W-1:0] fx;
        logic signed [SAMPLE_W-1:0] fy;
        for (int phase = 0; phase < 8; phase++) begin
            if ($urandom_range(0, 4) == 0)
                write_declination(SAMPLE_W'($urandom));
            else
                write_declination(SAMPLE_W'($urandom_range(0, 2 * HALF_CIRCLE)
                                            - HALF_CIRCLE));
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 220; n++) begin
                // sender pauses once mid-phase until the pipeline runs dry
                if (phase == 3 && n == 110)
                    wait_headings_drained();
                draw_sample(fx, fy);
                send_sample(fx, fy);
            end
            wait_headings_drained();
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;
    endtask

    // long receiver hold-off while the sender streams back to back
    task automatic test_output_backpressure();
        logic signed [SAMPLE_W-1:0] fx;
        logic signed [SAMPLE_W-1:0] fy;
        hold_cycles = 400;
        tx_fast = 1'b1;
        for (int n = 0; n < 120; n++) begin
            draw_sample(fx, fy);
            send_sample(fx, fy);
        end
        tx_fast = 1'b0;
        wait_headings_drained();
    endtask

    // result side ready: random stall per beat, or a requested long hold
    initial begin : heading_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_cycles != 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = rx_fast ? 0 : $urandom_range(0, 13);
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        heading_exp_t exp_beat;
        if (aresetn && m_tvalid && m_tready) begin
            if (heading_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected heading beat %0d", m_tdata);
            end else begin
                exp_beat = heading_q.pop_front();
                if (m_tdata !== exp_beat.heading) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("heading mismatch x=%0d y=%0d: expected %0d, got %0d",
                                 exp_beat.x, exp_beat.y, exp_beat.heading, m_tdata);
                end
            end
        end
    end

    // test sequence
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        decl_setting = DECL_AT_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_declination();
        test_declination_extremes();
        test_random_headings();
        test_output_backpressure();

        wait_headings_drained();
        repeat (PIPE_LATENCY + 16) @(posedge aclk);
        if (mismatch_count == 0 && heading_q.size() == 0)
            $display("compass_heading_from_xy test passed");
        else
            $display("compass_heading_from_xy test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/chf_pkg.sv
rtl/chf_prerot.sv
rtl/chf_cell.sv
rtl/chf_fold.sv
rtl/compass_heading_from_xy.sv
tb/compass_heading_from_xy_test.sv
